/* design/lmbs_pkg.sv */
package lmbs_pkg;

  localparam int NUM_ROWS           = 32;
  localparam int NUM_COLS           = 42;
  localparam int FS_DEPTH           = NUM_ROWS * NUM_COLS;
  localparam int FS_AW              = $clog2(FS_DEPTH);
  localparam int PIXEL_W            = 24;
  localparam int SHIFT_BITS         = 193;
  localparam int BIT_LEVELS_DEFAULT = 8;
  localparam logic [8:0] BASE_PERIOD_RESET = 9'd10;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [4:0] pixel_row;
    logic [5:0] pixel_col;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } in_item_t;

  typedef struct packed {
    logic [4:0] row_address;
    logic       output_off;
    logic       latch_open;
    logic       shift_strobe;
    logic       serial_red;
    logic       serial_green;
    logic       serial_blue;
  } out_item_t;

  // What the scan sequencer reports for the tick about to be taken
  typedef struct packed {
    logic [4:0]       row_address;
    logic             shifting;
    logic             use_data;
    logic [2:0]       bit_sel;
    logic [FS_AW-1:0] raddr;
  } scan_info_t;

  // Row-major frame store address: row * 42 + col
  function automatic logic [FS_AW-1:0] fs_addr(input logic [4:0] row, input logic [5:0] col);
    logic [FS_AW-1:0] r;
    r = FS_AW'(row);
    return (r << 5) + (r << 3) + (r << 1) + FS_AW'(col);
  endfunction

endpackage

/* design/lmbs_ram.sv */
module lmbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1344
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/lmbs_scan.sv */
module lmbs_scan import lmbs_pkg::*; #(
  parameter int BIT_LEVELS = BIT_LEVELS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [8:0] base_period,
  output scan_info_t info
);

  localparam logic [2:0] BIT_OFFSET = 3'(8 - BIT_LEVELS);
  localparam logic [3:0] PLANES     = 4'(BIT_LEVELS);

  logic [1:0]  group_index, group_index_next;
  logic [2:0]  line_index, line_index_next;
  logic [2:0]  plane_index, plane_index_next;
  logic        shifting, shifting_next;
  logic [7:0]  shift_position, shift_position_next;
  logic [15:0] dwell_count, dwell_count_next;

  logic [7:0]  pos_inc;
  logic [15:0] dwell_inc;
  logic [15:0] dwell_limit;
  logic [3:0]  plane_inc;

  // Serial position to frame store row and column
  logic [7:0] q8;
  logic [6:0] q;
  logic [6:0] col;
  logic [4:0] row;
  logic       split;
  logic       hit;

  always_comb begin
    row   = 5'd0;
    q8    = 8'd0;
    split = 1'b0;
    hit   = 1'b1;
    col   = 7'd0;
    if (shift_position < 8'd48) begin
      row   = {2'b11, line_index};
      q8    = shift_position;
      split = 1'b1;
    end else if (shift_position >= 8'd51 && shift_position < 8'd93) begin
      row = {2'b10, line_index};
      col = 7'(8'd92 - shift_position);
    end else if (shift_position >= 8'd96 && shift_position < 8'd144) begin
      row   = {2'b01, line_index};
      q8    = shift_position - 8'd96;
      split = 1'b1;
    end else if (shift_position >= 8'd147 && shift_position < 8'd189) begin
      row = {2'b00, line_index};
      col = 7'(8'd188 - shift_position);
    end else begin
      hit = 1'b0;
    end
    q = q8[6:0];
    if (split) begin
      if (q < 7'd13) begin
        col = 7'd12 - q;
      end else if (q >= 7'd16 && q < 7'd32) begin
        col = 7'd44 - q;
      end else if (q >= 7'd35 && q < 7'd48) begin
        col = 7'd76 - q;
      end else begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    info.row_address = {group_index, line_index};
    info.shifting    = shifting;
    info.use_data    = shifting & hit;
    info.bit_sel     = BIT_OFFSET + plane_index;
    info.raddr       = fs_addr(row, col[5:0]);
  end

  // Next scan state for one tick
  always_comb begin
    group_index_next    = group_index;
    line_index_next     = line_index;
    plane_index_next    = plane_index;
    shifting_next       = shifting;
    shift_position_next = shift_position;
    dwell_count_next    = dwell_count;

    pos_inc     = shift_position + 8'd1;
    dwell_inc   = dwell_count + 16'd1;
    dwell_limit = {7'd0, base_period} << plane_index;
    plane_inc   = {1'b0, plane_index} + 4'd1;

    if (shifting) begin
      shift_position_next = pos_inc;
      if (pos_inc >= 8'(SHIFT_BITS) || pos_inc == 8'd0) begin
        shifting_next       = 1'b0;
        shift_position_next = 8'd0;
        dwell_count_next    = 16'd0;
      end
    end else begin
      dwell_count_next = dwell_inc;
      if (dwell_inc >= dwell_limit || dwell_inc == 16'd0) begin
        dwell_count_next = 16'd0;
        group_index_next = group_index + 2'd1;
        if (group_index == 2'd3) begin
          plane_index_next = plane_inc[2:0];
          if (plane_inc >= PLANES) begin
            plane_index_next = 3'd0;
            line_index_next  = line_index + 3'd1;
          end
          shifting_next       = 1'b1;
          shift_position_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_index    <= 2'd0;
      line_index     <= 3'd0;
      plane_index    <= 3'd0;
      shifting       <= 1'b1;
      shift_position <= 8'd0;
      dwell_count    <= 16'd0;
    end else if (advance) begin
      group_index    <= group_index_next;
      line_index     <= line_index_next;
      plane_index    <= plane_index_next;
      shifting       <= shifting_next;
      shift_position <= shift_position_next;
      dwell_count    <= dwell_count_next;
    end
  end

endmodule

/* design/led_matrix_bitplane_scanner_top.sv */
// LED matrix bit-plane scanner for a 32 x 42 RGB panel (binary code modulation).
// Input channel (item_valid / item_ready / item): an item with action 0 writes
// one 24-bit pixel into the frame store (columns beyond 41 are dropped) and
// gives no result; an item with action 1 is one scan tick and gives exactly one
// result item (pin word) on the result channel (result_valid / result_ready).
// Each display cycle shifts 193 serial bits of the current bit plane with the
// latch open and outputs blanked, then shows four row groups, each for
// base_period << plane ticks.
// cfg_we / cfg_data write base_period (reset value 10) with no wait.
// A tick's result passes through one frame store read stage and then the result
// register. Throughput: one item per cycle while the receiver does not stall,
// set by the single read/write port pair of the frame store.
// Reset: scan state returns to the first shift phase and the frame store is
// swept to black, one entry a cycle across all 1344 entries; item_ready stays
// low during the sweep.
// When the receiver stalls, the result register and read stage hold, and
// item_ready drops once both are full; nothing is lost or repeated.
module led_matrix_bitplane_scanner_top import lmbs_pkg::*; #(
  parameter int BIT_LEVELS = BIT_LEVELS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_item_t   item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data
);

  logic [8:0] base_period;

  // Frame store clearing sweep after reset
  logic             clearing;
  logic [FS_AW-1:0] clear_addr;

  // Read stage: one tick waiting for its frame store data
  logic       s1_valid;
  scan_info_t s1_info;
  logic       s1_load;
  logic       s1_move;

  logic       accept;
  logic       tick_accept;
  logic       pix_write;

  scan_info_t       info;
  logic             ram_we;
  logic [FS_AW-1:0] ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;
  logic [PIXEL_W-1:0] px_shifted;
  out_item_t        result_next;

  // Advance the read stage whenever the result register is free or draining
  assign s1_move     = !result_valid || result_ready;
  assign s1_load     = !s1_valid || s1_move;
  assign item_ready  = !clearing && s1_load;
  assign accept      = item_valid && item_ready;
  assign tick_accept = accept && (item.action == ACTION_TICK);
  assign pix_write   = accept && (item.action == ACTION_WRITE) &&
                       (item.pixel_col < 6'(NUM_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_period <= BASE_PERIOD_RESET;
    end else if (cfg_we) begin
      base_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == FS_AW'(FS_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Scan sequencer: info reflects the state before this tick's update
  lmbs_scan #(
    .BIT_LEVELS(BIT_LEVELS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (tick_accept),
    .base_period(base_period),
    .info       (info)
  );

  // Sweep writes black; otherwise take the pixel write
  assign ram_we    = clearing || pix_write;
  assign ram_waddr = clearing ? clear_addr : fs_addr(item.pixel_row, item.pixel_col);
  assign ram_wdata = clearing ? '0 : {item.red_level, item.green_level, item.blue_level};

  lmbs_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(FS_DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (tick_accept),
    .raddr(info.raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= tick_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_info <= info;
    end
  end

  // Pick the plane bit of each color; pads and display ticks drive zero
  always_comb begin
    px_shifted               = ram_rdata >> s1_info.bit_sel;
    result_next.row_address  = s1_info.row_address;
    result_next.output_off   = s1_info.shifting;
    result_next.latch_open   = s1_info.shifting;
    result_next.shift_strobe = s1_info.shifting;
    result_next.serial_red   = s1_info.use_data & px_shifted[16];
    result_next.serial_green = s1_info.use_data & px_shifted[8];
    result_next.serial_blue  = s1_info.use_data & px_shifted[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      result <= result_next;
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lmbs_pkg::*;

  // Cycles with no accepted item and no returned result before the run is declared hung.
  // Covers the frame store sweep of all 1344 entries after reset with a wide margin.
  localparam int HANG_LIMIT = 5000;

  // Predicts the pin word of every scan tick and checks the returned results in order.
  class scan_scoreboard;
    logic [23:0] pixels [NUM_ROWS*NUM_COLS];
    bit [1:0]    group_idx;
    bit [2:0]    line_idx;
    bit [2:0]    plane_idx;
    bit          shifting;
    bit [7:0]    shift_pos;
    bit [15:0]   dwell;
    bit [8:0]    period;
    out_item_t   expected_words[$];
    int          errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      group_idx = '0;
      line_idx  = '0;
      plane_idx = '0;
      shifting  = 1'b1;
      shift_pos = '0;
      dwell     = '0;
      period    = BASE_PERIOD_RESET;
      errors    = 0;
    endfunction

    function void set_period(bit [8:0] value);
      period = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Column within a split row segment (12..0, pad, 28..13, pad, 41..29), -1 on a pad.
    function int split_column(int q);
      if (q < 13) return 12 - q;
      if (q < 16) return -1;
      if (q < 32) return 28 - (q - 16);
      if (q < 35) return -1;
      if (q < 48) return 41 - (q - 35);
      return -1;
    endfunction

    // Frame store index for a serial position, -1 on a pad.
    function int serial_pixel(int p);
      int r;
      int c;
      r = 0;
      c = -1;
      if (p < 48) begin
        r = line_idx + 24;
        c = split_column(p);
      end else if (p >= 51 && p < 93) begin
        r = line_idx + 16;
        c = 41 - (p - 51);
      end else if (p >= 96 && p < 144) begin
        r = line_idx + 8;
        c = split_column(p - 96);
      end else if (p >= 147 && p < 189) begin
        r = line_idx;
        c = 41 - (p - 147);
      end
      if (c < 0) return -1;
      return (r % NUM_ROWS) * NUM_COLS + c;
    endfunction

    function void note_input(in_item_t it);
      out_item_t w;
      int        idx;
      int        bit_sel;
      int        dwell_limit;
      if (it.action == ACTION_WRITE) begin
        // drop writes past the last column
        if (it.pixel_col < NUM_COLS)
          pixels[it.pixel_row * NUM_COLS + it.pixel_col] =
            {it.red_level, it.green_level, it.blue_level};
        return;
      end
      w = '0;
      w.row_address = {group_idx, line_idx};
      if (shifting) begin
        w.output_off   = 1'b1;
        w.latch_open   = 1'b1;
        w.shift_strobe = 1'b1;
        bit_sel = 8 - BIT_LEVELS_DEFAULT + plane_idx;
        idx = serial_pixel(shift_pos);
        if (bit_sel < 8 && idx >= 0) begin
          w.serial_red   = pixels[idx][16 + bit_sel];
          w.serial_green = pixels[idx][8 + bit_sel];
          w.serial_blue  = pixels[idx][bit_sel];
        end
        shift_pos = shift_pos + 8'd1;
        if (shift_pos >= SHIFT_BITS || shift_pos == 0) begin
          shifting  = 1'b0;
          shift_pos = '0;
          dwell     = '0;
        end
      end else begin
        dwell = dwell + 16'd1;
        dwell_limit = int'(period) << plane_idx;
        if (dwell >= dwell_limit || dwell == 0) begin
          dwell = '0;
          group_idx = group_idx + 2'd1;
          if (group_idx == 0) begin
            plane_idx = plane_idx + 3'd1;
            if (plane_idx >= BIT_LEVELS_DEFAULT || plane_idx == 0) begin
              plane_idx = '0;
              line_idx  = line_idx + 3'd1;
            end
            shifting  = 1'b1;
            shift_pos = '0;
          end
        end
      end
      expected_words.push_back(w);
    endfunction

    function void field_check(string field, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        if (errors < 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        if (errors < 40)
          $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      field_check("row_address", want.row_address, got.row_address);
      field_check("output_off", 5'(want.output_off), 5'(got.output_off));
      field_check("latch_open", 5'(want.latch_open), 5'(got.latch_open));
      field_check("shift_strobe", 5'(want.shift_strobe), 5'(got.shift_strobe));
      field_check("serial_red", 5'(want.serial_red), 5'(got.serial_red));
      field_check("serial_green", 5'(want.serial_green), 5'(got.serial_green));
      field_check("serial_blue", 5'(want.serial_blue), 5'(got.serial_blue));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  in_item_t   item = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  out_item_t  result;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int quiet_cycles = 0;

  scan_scoreboard sb;

  led_matrix_bitplane_scanner_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Sample both channels at the edge. Check the result before noting the
  // input: a tick never returns its result at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result);
      if (item_valid && item_ready) sb.note_input(item);
    end
  end

  // Drop result_ready at random according to the current stall rate.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Count cycles in which nothing moves on either channel; end a hung run.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t pixel_item(int row, int col, int red, int green, int blue);
    in_item_t it;
    it.action      = ACTION_WRITE;
    it.pixel_row   = 5'(row);
    it.pixel_col   = 6'(col);
    it.red_level   = 8'(red);
    it.green_level = 8'(green);
    it.blue_level  = 8'(blue);
    return it;
  endfunction

  // Bias levels toward black and full scale, otherwise anything.
  function automatic int level_value();
    case ($urandom_range(5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic in_item_t random_pixel();
    int col;
    // one write in eight aims past the last column and must be dropped
    col = ($urandom_range(7) == 0) ? $urandom_range(63, 42) : $urandom_range(41);
    return pixel_item($urandom_range(31), col, level_value(), level_value(), level_value());
  endfunction

  // Scan tick with junk in the pixel fields, which the block must ignore.
  function automatic in_item_t tick_item();
    in_item_t it;
    it = pixel_item($urandom_range(31), $urandom_range(63), $urandom_range(255),
                    $urandom_range(255), $urandom_range(255));
    it.action = ACTION_TICK;
    return it;
  endfunction

  // Present one item and hold it until accepted. Pick the idle and stall
  // rates from the running item count so every mode gets long stretches.
  task automatic send_item(input in_item_t it);
    case ((sent / 150) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 49; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 49; end
      default: begin idle_pct = 26; stall_pct = 26; end
    endcase
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait for every expected result.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_period(input logic [8:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_period(value);
  endtask

  // Random stream: tick_pct percent scan ticks, the rest pixel writes.
  task automatic run_random(input int count, input int tick_pct);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      // hold the sender once mid-run until the result queue drains
      if (sent == 1000) settle();
      if ($urandom_range(99) < tick_pct) it = tick_item();
      else it = random_pixel();
      send_item(it);
    end
  endtask

  task automatic directed();
    // First serial bit of line 0, then segment edges of each row band
    send_item(pixel_item(24, 12, 255, 255, 255));
    send_item(pixel_item(24, 0, 8'h01, 8'h80, 8'h55));
    send_item(pixel_item(24, 28, 8'h81, 8'h00, 8'hff));
    send_item(pixel_item(24, 41, 255, 0, 255));
    send_item(pixel_item(16, 41, 255, 255, 255));
    send_item(pixel_item(16, 0, 0, 255, 0));
    send_item(pixel_item(8, 13, 8'haa, 8'h55, 8'h01));
    send_item(pixel_item(0, 41, 8'h01, 8'h01, 8'h01));
    send_item(pixel_item(0, 0, 255, 255, 255));
    send_item(pixel_item(31, 41, 255, 255, 255));
    send_item(pixel_item(31, 0, 8'h7f, 8'hfe, 8'h80));
    // Columns past 41 must not land anywhere, e.g. the next row's column 0
    send_item(pixel_item(24, 42, 255, 255, 255));
    send_item(pixel_item(31, 63, 255, 255, 255));
    send_item(pixel_item(0, 63, 255, 255, 255));
    // Overwrite a lit pixel back to black
    send_item(pixel_item(16, 41, 0, 0, 0));
    repeat (8) send_item(tick_item());
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // item_ready stays low while the frame store is swept to black
    @(posedge clk);
    while (!item_ready) @(posedge clk);

    // Reset base period first, then zero (one tick per group, the range floor), one,
    // the ceiling and a small value. The long zero-period stretch
    // walks every plane and advances the line.
    directed();
    run_random(40, 60);
    program_period(9'd0);
    run_random(1620, 98);
    program_period(9'd1);
    run_random(30, 70);
    program_period(9'd511);
    run_random(20, 70);
    program_period(9'd2);
    run_random(30, 70);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
